/* sv/byte_ring_fifo_core_assert.svh */
// Assertion macros for the byte ring FIFO.
// Expects clk_i and rst_ni in the scope of use.
`ifndef BYTE_RING_FIFO_CORE_ASSERT_SVH
`define BYTE_RING_FIFO_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/brf_pkg.sv */
// Shared types, constants and helpers for the byte ring FIFO.
// No dependencies.
package brf_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = 9;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic             ok;
    logic [7:0]       rdata;
    logic [CNT_W-1:0] fill_count;
    logic             is_full;
  } out_item_t;

  typedef struct packed {
    logic capture;  // latch the accepted operation
    logic execute;  // perform it and load the result register
  } brf_cmd_t;

  // Step a pointer, wrapping to zero at the capacity
  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr,
                                                   input logic [CNT_W-1:0] cap);
    logic [PTR_W:0] nxt;
    nxt = {1'b0, ptr} + (PTR_W+1)'(1);
    if (CNT_W'(nxt) >= cap) begin
      ptr_advance = '0;
    end else begin
      ptr_advance = nxt[PTR_W-1:0];
    end
  endfunction

endpackage

/* sv/brf_ctrl.sv */
// Controller for the byte ring FIFO: operation sequencing and result valid.
// Depends on brf_pkg.
module brf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output brf_pkg::brf_cmd_t cmd_o
);
  import brf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   exec_go;

  // Result register is free when empty or being drained this cycle
  assign exec_go = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    cmd_o.capture = in_valid_i && (state_q == ST_IDLE);
    cmd_o.execute = exec_go;
    if (exec_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/brf_dp.sv */
// Datapath for the byte ring FIFO: store, pointers, count, capacity, result.
// Depends on brf_pkg.
module brf_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  brf_pkg::brf_cmd_t         cmd_i,
  input  brf_pkg::in_item_t         in_item_i,
  input  logic                      cfg_we_i,
  input  logic [brf_pkg::CNT_W-1:0] cfg_wdata_i,
  output brf_pkg::out_item_t        out_item_o
);
  import brf_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       mem_rdata_q;
  logic             mem_we;

  in_item_t         op_q;
  out_item_t        out_q, out_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cap_q, cap_d;
  logic             can_write, can_read, ok;

  // Saturate the programmed capacity at the store depth
  assign cap_d = (cfg_wdata_i > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg_wdata_i;

  assign can_write = (cap_q != '0) && (count_q < cap_q);
  assign can_read  = (cap_q != '0) && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    ok       = 1'b0;
    mem_we   = 1'b0;
    unique case (op_q.func)
      FUNC_WRITE: begin
        if (can_write) begin
          ok       = 1'b1;
          mem_we   = cmd_i.execute;
          wr_ptr_d = ptr_advance(wr_ptr_q, cap_q);
          count_d  = count_q + CNT_W'(1);
        end
      end
      FUNC_READ: begin
        if (can_read) begin
          ok       = 1'b1;
          rd_ptr_d = ptr_advance(rd_ptr_q, cap_q);
          count_d  = count_q - CNT_W'(1);
        end
      end
      FUNC_FLUSH: begin
        ok       = 1'b1;
        wr_ptr_d = '0;
        rd_ptr_d = '0;
        count_d  = '0;
      end
      default: ok = 1'b0;
    endcase

    out_d.ok         = ok;
    out_d.rdata      = (ok && op_q.func == FUNC_READ) ? mem_rdata_q : 8'd0;
    out_d.fill_count = count_d;
    out_d.is_full    = (count_d >= cap_q);
  end

  // Read port follows the read pointer, so the head byte is ready at execute
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_ptr_q] <= op_q.wdata;
    mem_rdata_q <= mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      cap_q    <= CNT_W'(DEPTH);
    end else begin
      if (cfg_we_i) cap_q <= cap_d;
      if (cmd_i.execute) begin
        wr_ptr_q <= wr_ptr_d;
        rd_ptr_q <= rd_ptr_d;
        count_q  <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) op_q  <= in_item_i;
    if (cmd_i.execute) out_q <= out_d;
  end

  assign out_item_o = out_q;

endmodule

/* sv/byte_ring_fifo_core.sv */
// Top level of the byte ring FIFO: controller plus datapath.
// Depends on brf_pkg, brf_ctrl, brf_dp and byte_ring_fifo_core_assert.svh.
//
//   channel   signals                       transfer when
//   -------   ---------------------------   -------------------------
//   in        in_valid_i/in_ready_o/item    in_valid_i && in_ready_o
//   out       out_valid_o/out_ready_i/item  out_valid_o && out_ready_i
//   cfg       cfg_we_i/cfg_wdata_i          cfg_we_i (capacity, no wait)
//
// Each transfer is taken in the idle state; the execute state then executes
// it and loads the result register. The store has one write and one read port;
// the read port tracks the read pointer, so the head byte is already registered.
// A held result stalls execute until it drains; a new transfer can be taken
// while the previous result still waits. Reset clears pointers and count and
// sets the capacity to the full depth; the store itself is not cleared.
module byte_ring_fifo_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  brf_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output brf_pkg::out_item_t        out_item_o,
  input  logic                      cfg_we_i,
  input  logic [brf_pkg::CNT_W-1:0] cfg_wdata_i
);
  import brf_pkg::*;

  `include "byte_ring_fifo_core_assert.svh"

  brf_cmd_t cmd;

  // Sequence each operation: take, execute, hold result
  brf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Store, pointers, fill count and the result register
  brf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_item_o  (out_item_o)
  );

  // One operation in flight: no transfer in the cycle after one is taken
  `BRF_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o,
                   "input taken while an operation is in flight")

  // Execute always leaves a result waiting
  `BRF_ASSERT_NEXT(a_exec_loads, cmd.execute, out_valid_o,
                   "execute did not present a result")

  // A refused operation returns no data, and the count never exceeds the depth
  `BRF_ASSERT_NOW(a_result_sane, out_valid_o,
                  (out_item_o.ok || out_item_o.rdata == 8'd0) &&
                  (out_item_o.fill_count <= CNT_W'(DEPTH)),
                  "inconsistent result item")

endmodule
